### src/psr_pkg.sv
// ----------------------------------------------------------------------------
// PID speed regulator package
// Shared widths, constants, register codes and structs for the regulator.
// ----------------------------------------------------------------------------
package psr_pkg;

  // Width of the saturating integral sum (valid range 32 to 64).
  localparam int SUM_WIDTH = 40;

  localparam int SPEED_W    = 16;
  localparam int GAIN_W     = 8;
  localparam int ERR_W      = SPEED_W + 1;
  localparam int DIFF_W     = ERR_W + 1;
  // P and D terms in hundredths: |P| < 1.7e8, |D| < 3.4e7, so 29 signed bits.
  localparam int TERM_W     = 29;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Floor division of the P+D term by 100. The term is biased by 100 * 2^22,
  // which makes it positive and below 2^30, then divided by a reciprocal
  // multiply that is at most one short of the true quotient.
  localparam int DIVISOR     = 100;
  localparam int BIAS_EXP    = 22;
  localparam int U_W         = 30;
  localparam int QUO_W       = 23;
  localparam int RECIP_SHIFT = 32;
  localparam int RECIP_W     = 26;

  localparam logic [U_W-1:0]     BIAS  = U_W'(DIVISOR * (2 ** BIAS_EXP));
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / DIVISOR);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_P_GAIN    = 3'd0,
    REG_I_GAIN    = 3'd1,
    REG_D_GAIN    = 3'd2,
    REG_DRIVE_MIN = 3'd3,
    REG_DRIVE_MAX = 3'd4
  } psr_reg_t;

  typedef struct packed {
    logic        [GAIN_W-1:0]  p_gain;
    logic        [GAIN_W-1:0]  i_gain;
    logic        [GAIN_W-1:0]  d_gain;
    logic signed [SPEED_W-1:0] drive_min;
    logic signed [SPEED_W-1:0] drive_max;
  } psr_cfg_t;

  typedef struct packed {
    logic ld_mid;
    logic ld_out;
  } psr_div_ctl_t;

endpackage

### src/psr_in_if.sv
// ----------------------------------------------------------------------------
// PID speed regulator input channel
// Valid/ready channel that carries one speed sample transaction.
// ----------------------------------------------------------------------------
interface psr_in_if;

  logic                                valid;
  logic                                ready;
  logic signed [psr_pkg::SPEED_W-1:0]  target_speed;
  logic signed [psr_pkg::SPEED_W-1:0]  measured_speed;
  logic                                drive_enable;

  modport source (
    output valid,
    output target_speed,
    output measured_speed,
    output drive_enable,
    input  ready
  );

  modport sink (
    input  valid,
    input  target_speed,
    input  measured_speed,
    input  drive_enable,
    output ready
  );

endinterface

### src/psr_out_if.sv
// ----------------------------------------------------------------------------
// PID speed regulator result channel
// Valid/ready channel that carries one drive command transaction.
// ----------------------------------------------------------------------------
interface psr_out_if;

  logic                                valid;
  logic                                ready;
  logic signed [psr_pkg::SPEED_W-1:0]  drive_value;

  modport source (
    output valid,
    output drive_value,
    input  ready
  );

  modport sink (
    input  valid,
    input  drive_value,
    output ready
  );

endinterface

### src/psr_cfg_regs.sv
// ----------------------------------------------------------------------------
// PID speed regulator configuration registers
// Gains and output limits, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module psr_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [psr_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [psr_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output psr_pkg::psr_cfg_t                   cfg_r
);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.p_gain    <= '0;
      cfg_r.i_gain    <= '0;
      cfg_r.d_gain    <= '0;
      cfg_r.drive_min <= {1'b1, {(psr_pkg::SPEED_W-1){1'b0}}};
      cfg_r.drive_max <= {1'b0, {(psr_pkg::SPEED_W-1){1'b1}}};
    end else if (cfg_we) begin
      unique case (psr_pkg::psr_reg_t'(cfg_idx))
        psr_pkg::REG_P_GAIN:    cfg_r.p_gain    <= cfg_wdata[psr_pkg::GAIN_W-1:0];
        psr_pkg::REG_I_GAIN:    cfg_r.i_gain    <= cfg_wdata[psr_pkg::GAIN_W-1:0];
        psr_pkg::REG_D_GAIN:    cfg_r.d_gain    <= cfg_wdata[psr_pkg::GAIN_W-1:0];
        psr_pkg::REG_DRIVE_MIN: cfg_r.drive_min <= $signed(cfg_wdata[psr_pkg::SPEED_W-1:0]);
        psr_pkg::REG_DRIVE_MAX: cfg_r.drive_max <= $signed(cfg_wdata[psr_pkg::SPEED_W-1:0]);
        default: begin
        end
      endcase
    end
  end

endmodule

### src/psr_law.sv
// ----------------------------------------------------------------------------
// PID speed regulator control law stage
// Forms the error, updates the stored error and integral, and registers the
// P+D term in hundredths together with the new integral.
// ----------------------------------------------------------------------------
module psr_law (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   adv,
  input  logic signed [psr_pkg::SPEED_W-1:0]     target_speed,
  input  logic signed [psr_pkg::SPEED_W-1:0]     measured_speed,
  input  logic                                   drive_enable,
  input  psr_pkg::psr_cfg_t                      cfg,
  output logic signed [psr_pkg::TERM_W-1:0]      term_r,
  output logic signed [psr_pkg::SUM_WIDTH-1:0]   sum_r
);

  localparam logic signed [psr_pkg::SUM_WIDTH-1:0] SUM_MAX =
    {1'b0, {(psr_pkg::SUM_WIDTH-1){1'b1}}};
  localparam logic signed [psr_pkg::SUM_WIDTH-1:0] SUM_MIN =
    {1'b1, {(psr_pkg::SUM_WIDTH-1){1'b0}}};

  logic signed [psr_pkg::ERR_W-1:0]             last_error_r;
  logic signed [psr_pkg::SUM_WIDTH-1:0]         error_sum_r;

  logic signed [psr_pkg::ERR_W-1:0]             err;
  logic signed [psr_pkg::DIFF_W-1:0]            err_diff;
  logic        [psr_pkg::GAIN_W-1:0]            kp;
  logic        [psr_pkg::GAIN_W-1:0]            ki;
  logic signed [psr_pkg::ERR_W+psr_pkg::GAIN_W:0]  p_prod;
  logic signed [psr_pkg::ERR_W+psr_pkg::GAIN_W:0]  i_prod;
  logic signed [psr_pkg::DIFF_W+psr_pkg::GAIN_W:0] d_prod;
  logic signed [psr_pkg::TERM_W-1:0]            p_ext;
  logic signed [psr_pkg::TERM_W-1:0]            term_nxt;
  logic signed [psr_pkg::SUM_WIDTH-1:0]         sum_base;
  logic signed [psr_pkg::SUM_WIDTH:0]           sum_wide;
  logic signed [psr_pkg::SUM_WIDTH-1:0]         sum_nxt;

  always_comb begin
    // With the drive disabled, P and I gains count as zero and the sum restarts.
    kp       = drive_enable ? cfg.p_gain : '0;
    ki       = drive_enable ? cfg.i_gain : '0;
    err      = $signed({target_speed[psr_pkg::SPEED_W-1], target_speed})
             - $signed({measured_speed[psr_pkg::SPEED_W-1], measured_speed});
    err_diff = $signed({err[psr_pkg::ERR_W-1], err})
             - $signed({last_error_r[psr_pkg::ERR_W-1], last_error_r});

    p_prod   = err * $signed({1'b0, kp});
    i_prod   = err * $signed({1'b0, ki});
    d_prod   = err_diff * $signed({1'b0, cfg.d_gain});

    // P in hundredths is err * kp * 10, done as two shifts and an add.
    p_ext    = (psr_pkg::TERM_W)'(p_prod);
    term_nxt = (p_ext <<< 3) + (p_ext <<< 1) + (psr_pkg::TERM_W)'(d_prod);

    sum_base = drive_enable ? error_sum_r : '0;
    sum_wide = (psr_pkg::SUM_WIDTH+1)'(sum_base) + (psr_pkg::SUM_WIDTH+1)'(i_prod);
    if (sum_wide[psr_pkg::SUM_WIDTH] != sum_wide[psr_pkg::SUM_WIDTH-1]) begin
      sum_nxt = sum_wide[psr_pkg::SUM_WIDTH] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_nxt = $signed(sum_wide[psr_pkg::SUM_WIDTH-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_error_r <= '0;
      error_sum_r  <= '0;
    end else if (adv) begin
      last_error_r <= err;
      error_sum_r  <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      term_r <= term_nxt;
      sum_r  <= sum_nxt;
    end
  end

endmodule

### src/psr_div.sv
// ----------------------------------------------------------------------------
// PID speed regulator scaling and clamp stages
// Divides the hundredths total by 100 with truncation toward zero, using a
// reciprocal multiply and one correction step, then clamps to the limits.
// ----------------------------------------------------------------------------
module psr_div (
  input  logic                                   clk,
  input  psr_pkg::psr_div_ctl_t                  ctl,
  input  logic signed [psr_pkg::TERM_W-1:0]      term,
  input  logic signed [psr_pkg::SUM_WIDTH-1:0]   sum,
  input  logic signed [psr_pkg::SPEED_W-1:0]     drive_min,
  input  logic signed [psr_pkg::SPEED_W-1:0]     drive_max,
  output logic signed [psr_pkg::SPEED_W-1:0]     drive_value_r
);

  localparam int PROD_W = psr_pkg::U_W + psr_pkg::RECIP_W;
  localparam int V_W    = psr_pkg::SUM_WIDTH + 2;
  localparam logic signed [psr_pkg::QUO_W:0] QBIAS =
    (psr_pkg::QUO_W+1)'(2 ** psr_pkg::BIAS_EXP);

  // First stage: biased term and estimated quotient.
  logic [psr_pkg::U_W-1:0]              u;
  logic [PROD_W-1:0]                    prod;
  logic [psr_pkg::U_W-1:0]              u_r;
  logic [psr_pkg::QUO_W-1:0]            q0_r;
  logic signed [psr_pkg::SUM_WIDTH-1:0] sum_mid_r;

  // Second stage: correction, recombination and clamp.
  logic [psr_pkg::U_W-1:0]              rem;
  logic                                 fix;
  logic                                 rem_nz;
  logic [psr_pkg::QUO_W-1:0]            q;
  logic signed [psr_pkg::QUO_W:0]       fq;
  logic signed [psr_pkg::SUM_WIDTH:0]   w;
  logic                                 round_up;
  logic signed [V_W-1:0]                v;
  logic signed [V_W-1:0]                min_ext;
  logic signed [V_W-1:0]                max_ext;
  logic signed [psr_pkg::SPEED_W-1:0]   drive_nxt;

  always_comb begin
    u    = (psr_pkg::U_W)'(term) + psr_pkg::BIAS;
    prod = PROD_W'(u) * PROD_W'(psr_pkg::RECIP);
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_mid) begin
      u_r       <= u;
      q0_r      <= prod[psr_pkg::RECIP_SHIFT +: psr_pkg::QUO_W];
      sum_mid_r <= sum;
    end
  end

  always_comb begin
    // The estimate is the true quotient or one below it.
    rem      = u_r - (psr_pkg::U_W)'(q0_r) * (psr_pkg::U_W)'(psr_pkg::DIVISOR);
    fix      = (rem >= (psr_pkg::U_W)'(psr_pkg::DIVISOR));
    rem_nz   = fix ? (rem != (psr_pkg::U_W)'(psr_pkg::DIVISOR)) : (rem != '0);
    q        = q0_r + (psr_pkg::QUO_W)'(fix);
    fq       = $signed({1'b0, q}) - QBIAS;

    // Floor of the total is sum + floor(term / 100); a negative total with a
    // nonzero remainder rounds up by one to truncate toward zero.
    w        = (psr_pkg::SUM_WIDTH+1)'(sum_mid_r) + (psr_pkg::SUM_WIDTH+1)'(fq);
    round_up = w[psr_pkg::SUM_WIDTH] & rem_nz;
    v        = $signed({w[psr_pkg::SUM_WIDTH], w}) + $signed({{(V_W-1){1'b0}}, round_up});

    min_ext  = V_W'(drive_min);
    max_ext  = V_W'(drive_max);
    if (v < min_ext) begin
      drive_nxt = drive_min;
    end else if (v > max_ext) begin
      drive_nxt = drive_max;
    end else begin
      drive_nxt = $signed(v[psr_pkg::SPEED_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_out) begin
      drive_value_r <= drive_nxt;
    end
  end

endmodule

### src/pid_speed_regulator.sv
// ----------------------------------------------------------------------------
// PID speed regulator
// Speed loop controller with saturating integral and clamped drive output.
// ----------------------------------------------------------------------------
// Each input transaction carries a target and a measured speed and returns
// exactly one drive command. The regulator accepts one transaction per clock
// cycle while no held result backs up the pipeline. The path holds four
// registers: input, control law, quotient estimate and result. The rate of
// one transaction per cycle holds because the control law stage reads and
// updates the stored error and integral sum at each advance, so consecutive
// samples follow each other without a gap; the division by 100 and the clamp
// sit in two further stages behind it. Each stage holds its transaction until
// the next one is free, so a stalled result does not block input while
// earlier stages still have room. The user must write gains and limits on
// the cfg port only while no transaction is in flight; the block does not
// enforce this. A write to an unknown index is ignored. The drive is
// err*p_gain/10 + sum + (err-prev)*d_gain/100, formed exactly in hundredths,
// truncated toward zero and clamped; when the drive is disabled only the
// derivative term acts and the sum is cleared.
// ----------------------------------------------------------------------------
module pid_speed_regulator (
  input  logic                              clk,
  input  logic                              rst_n,
  psr_in_if.sink                            in_ch,
  psr_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [psr_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [psr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int NSTG = 4;

  psr_pkg::psr_cfg_t                     cfg;
  psr_pkg::psr_div_ctl_t                 div_ctl;

  // Stage 0 is the input register, 1 the law output, 2 the quotient estimate
  // and 3 the result register.
  logic [NSTG-1:0]                       vld_r;
  logic [NSTG-1:0]                       vld_nxt;
  logic [NSTG-1:0]                       rdy;
  logic [NSTG-1:0]                       ld;
  logic                                  out_take;

  logic signed [psr_pkg::SPEED_W-1:0]    target_r;
  logic signed [psr_pkg::SPEED_W-1:0]    measured_r;
  logic                                  enable_r;

  logic signed [psr_pkg::TERM_W-1:0]     term;
  logic signed [psr_pkg::SUM_WIDTH-1:0]  sum;
  logic signed [psr_pkg::SPEED_W-1:0]    drive_value;

  psr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg_r     (cfg)
  );

  // A stage can load when it is empty or its transaction moves on this cycle.
  always_comb begin
    out_take = vld_r[NSTG-1] & out_ch.ready;
    rdy[NSTG-1] = ~vld_r[NSTG-1] | out_ch.ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      rdy[i] = ~vld_r[i] | rdy[i+1];
    end
    ld[0] = in_ch.valid & rdy[0];
    for (int i = 1; i < NSTG; i++) begin
      ld[i] = vld_r[i-1] & rdy[i];
    end
    for (int i = 0; i < NSTG - 1; i++) begin
      vld_nxt[i] = ld[i] | (vld_r[i] & ~ld[i+1]);
    end
    vld_nxt[NSTG-1] = ld[NSTG-1] | (vld_r[NSTG-1] & ~out_take);
    div_ctl.ld_mid = ld[2];
    div_ctl.ld_out = ld[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      target_r   <= in_ch.target_speed;
      measured_r <= in_ch.measured_speed;
      enable_r   <= in_ch.drive_enable;
    end
  end

  // The stored error and integral advance when a sample leaves the input
  // register, which keeps them in transaction order.
  psr_law u_law (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (ld[1]),
    .target_speed   (target_r),
    .measured_speed (measured_r),
    .drive_enable   (enable_r),
    .cfg            (cfg),
    .term_r         (term),
    .sum_r          (sum)
  );

  psr_div u_div (
    .clk           (clk),
    .ctl           (div_ctl),
    .term          (term),
    .sum           (sum),
    .drive_min     (cfg.drive_min),
    .drive_max     (cfg.drive_max),
    .drive_value_r (drive_value)
  );

  assign in_ch.ready        = rdy[0];
  assign out_ch.valid       = vld_r[NSTG-1];
  assign out_ch.drive_value = drive_value;

`ifndef NO_ASSERTIONS
  // Input is only refused when a finished result is being held back.
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (vld_r[NSTG-1] && !out_ch.ready))
    else $error("input refused without a held result");

  // With ordered limits, every delivered drive lies inside them.
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (cfg.drive_min <= cfg.drive_max)) |->
      (out_ch.drive_value >= cfg.drive_min && out_ch.drive_value <= cfg.drive_max))
    else $error("drive value outside configured limits");

  // A transaction entering an empty pipeline reaches the result register.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (ld[0] && (vld_r == '0)) |-> ##4 vld_r[NSTG-1])
    else $error("result missing four cycles after acceptance");
`endif

endmodule
